>>> rtl/core/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_KEEP = 3'd4
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

endpackage

>>> rtl/core/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/pse_alu.sv
// Shared arithmetic unit: add, subtract and multiply with a registered result; bit-serial signed divide.
module pse_alu
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output alu_rsp_t          rsp,
    output logic [DATA_W-1:0] result
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic                 dz_reg, dz_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    res_reg, res_next;

    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[DATA_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        a_mag  = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
        b_mag  = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dz_next   = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;

        if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_next = diff[DATA_W] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
                cnt_next = cnt_reg - 1'b1;
            end
            else
            begin
                res_next  = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
        end
        else if (req.start)
        begin
            unique case (req.op)
                OP_ADD:
                begin
                    res_next  = a + b;
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    res_next  = a - b;
                    done_next = 1'b1;
                end
                OP_MUL:
                begin
                    res_next  = a * b;
                    done_next = 1'b1;
                end
                OP_DIV:
                begin
                    if (b == '0)
                    begin
                        res_next  = '0;
                        dz_next   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next  = '0;
                        quo_next  = a_mag;
                        den_next  = b_mag;
                        neg_next  = a[DATA_W-1] ^ b[DATA_W-1];
                        cnt_next  = DIV_CNT_W'(DATA_W);
                        busy_next = 1'b1;
                    end
                end
                default:
                begin
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            dz_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            dz_reg   <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.div_zero = dz_reg;
    assign result       = res_reg;

endmodule

>>> rtl/core/postfix_stack_evaluator.sv
// Postfix expression evaluator top level: request sequencer, value stack, result register.
// Each request carries one expression character. A digit is pushed as it is accepted; a
// zero byte, and any byte after it up to tlast, is skipped. An operator pops two values
// from the stack RAM (POP_B, POP_A, CAP_A), runs the shared arithmetic unit (EXEC, WAIT)
// and pushes the result (PUSH); a divide waits on the bit-serial divider unless the
// divisor is zero. Any other byte skips the arithmetic unit and pushes the last result
// again. With tlast set, the final pop (FIN_RD, FIN_CAP) holds while the previous result
// is not taken; the result register lets the next expression start while it waits.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] symbol
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] result
    output logic [2:0]        m_axis_tuser    // [0] divide_by_zero, [1] stack_overflow,
                                              // [2] stack_underflow
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_POP_B   = 9'b000000010,
        ST_POP_A   = 9'b000000100,
        ST_CAP_A   = 9'b000001000,
        ST_EXEC    = 9'b000010000,
        ST_WAIT    = 9'b000100000,
        ST_PUSH    = 9'b001000000,
        ST_FIN_RD  = 9'b010000000,
        ST_FIN_CAP = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] last_val_reg, last_val_next;
    logic              dz_reg, dz_next;
    logic              ovf_reg, ovf_next;
    logic              unf_reg, unf_next;
    logic              skip_reg, skip_next;
    logic              empty_reg, empty_next;
    op_t               op_reg, op_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] op_a_reg, op_a_next;
    logic [DATA_W-1:0] op_b_reg, op_b_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]        m_user_reg, m_user_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic [DATA_W-1:0] alu_result;

    logic [CNT_W-1:0]  count_dec;
    logic              stack_full;
    logic              stack_empty;
    logic              in_fire;
    logic              out_free;
    logic [DATA_W-1:0] pop_data;
    op_t               sym_op;

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    pse_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (op_a_reg),
        .b      (op_b_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign count_dec     = count_reg - 1'b1;
    assign stack_full    = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stack_empty   = (count_reg == '0);
    assign pop_data      = empty_reg ? '0 : ram_rdata;

    always_comb
    begin
        case (s_axis_tdata)
            CH_PLUS:  sym_op = OP_ADD;
            CH_MINUS: sym_op = OP_SUB;
            CH_STAR:  sym_op = OP_MUL;
            CH_SLASH: sym_op = OP_DIV;
            default:  sym_op = OP_KEEP;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_val_next = last_val_reg;
        dz_next       = dz_reg;
        ovf_next      = ovf_reg;
        unf_next      = unf_reg;
        skip_next     = skip_reg;
        empty_next    = empty_reg;
        op_next       = op_reg;
        last_next     = last_reg;
        op_a_next     = op_a_reg;
        op_b_next     = op_b_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;

        ram_we        = 1'b0;
        ram_waddr     = count_reg[ADDR_W-1:0];
        ram_wdata     = last_val_reg;
        ram_re        = 1'b0;
        ram_raddr     = count_dec[ADDR_W-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    last_next = s_axis_tlast;
                    if (skip_reg || (s_axis_tdata == CH_NUL))
                    begin
                        skip_next  = 1'b1;
                        state_next = s_axis_tlast ? ST_FIN_RD : ST_IDLE;
                    end
                    else if ((s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE))
                    begin
                        if (stack_full)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {{(DATA_W-4){1'b0}}, s_axis_tdata[3:0]};
                            count_next = count_reg + 1'b1;
                        end
                        state_next = s_axis_tlast ? ST_FIN_RD : ST_IDLE;
                    end
                    else
                    begin
                        op_next    = sym_op;
                        state_next = ST_POP_B;
                    end
                end
            end
            ST_POP_B:
            begin
                if (stack_empty)
                begin
                    unf_next   = 1'b1;
                    empty_next = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    empty_next = 1'b0;
                    count_next = count_dec;
                end
                state_next = ST_POP_A;
            end
            ST_POP_A:
            begin
                op_b_next = pop_data;
                if (stack_empty)
                begin
                    unf_next   = 1'b1;
                    empty_next = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    empty_next = 1'b0;
                    count_next = count_dec;
                end
                state_next = ST_CAP_A;
            end
            ST_CAP_A:
            begin
                op_a_next  = pop_data;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (op_reg == OP_KEEP)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    alu_req.start = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    last_val_next = alu_result;
                    dz_next       = dz_reg || alu_rsp.div_zero;
                    state_next    = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (stack_full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = last_reg ? ST_FIN_RD : ST_IDLE;
            end
            ST_FIN_RD:
            begin
                if (stack_empty)
                begin
                    unf_next   = 1'b1;
                    empty_next = 1'b1;
                end
                else
                begin
                    ram_re     = 1'b1;
                    empty_next = 1'b0;
                end
                state_next = ST_FIN_CAP;
            end
            ST_FIN_CAP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = pop_data;
                    m_user_next   = {unf_reg, ovf_reg, dz_reg};
                    count_next    = '0;
                    last_val_next = '0;
                    dz_next       = 1'b0;
                    ovf_next      = 1'b0;
                    unf_next      = 1'b0;
                    skip_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            last_val_reg <= '0;
            dz_reg       <= 1'b0;
            ovf_reg      <= 1'b0;
            unf_reg      <= 1'b0;
            skip_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_val_reg <= last_val_next;
            dz_reg       <= dz_next;
            ovf_reg      <= ovf_next;
            unf_reg      <= unf_next;
            skip_reg     <= skip_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_reg  <= empty_next;
        op_reg     <= op_next;
        last_reg   <= last_next;
        op_a_reg   <= op_a_next;
        op_b_reg   <= op_b_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FIN_CAP))
        else $error("result raised outside final pop");

    a_clear_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN_CAP && out_free) |=> (count_reg == '0 && !skip_reg))
        else $error("evaluator not cleared after result");

    a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == ST_WAIT))
        else $error("arithmetic unit done outside wait state");

endmodule

>>> tb/tb_postfix_stack_evaluator.sv
`timescale 1ns / 100ps
// Testbench for postfix_stack_evaluator: directed and random expressions checked against a predictor.
module tb_postfix_stack_evaluator;
    import pse_pkg::*;

    localparam int GAP_PCT     = 36;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 100;

    typedef struct {
        logic [DATA_W-1:0] result;
        logic              divide_by_zero;
        logic              stack_overflow;
        logic              stack_underflow;
    } eval_result_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [2:0]        m_axis_tuser;

    logic [DATA_W-1:0] operand_stack [STACK_DEPTH];
    int                operand_count;
    logic [DATA_W-1:0] last_value;
    logic              dz_seen;
    logic              ovf_seen;
    logic              unf_seen;
    logic              skip_rest;

    eval_result_t      expected_results [$];
    bit                gaps_on;
    int                err_count;
    int                items_sent;
    int                stall_cycles;

    postfix_stack_evaluator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_expression();
        operand_count = 0;
        last_value    = '0;
        dz_seen       = 1'b0;
        ovf_seen      = 1'b0;
        unf_seen      = 1'b0;
        skip_rest     = 1'b0;
    endfunction

    function automatic void push_operand(input logic [DATA_W-1:0] value);
        if (operand_count >= STACK_DEPTH)
        begin
            ovf_seen = 1'b1;
        end
        else
        begin
            operand_stack[operand_count] = value;
            operand_count++;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pop_operand();
        if (operand_count == 0)
        begin
            unf_seen = 1'b1;
            return '0;
        end
        operand_count--;
        return operand_stack[operand_count];
    endfunction

    // quotient on magnitudes, truncated toward zero
    function automatic logic [DATA_W-1:0] divide_trunc(input logic [DATA_W-1:0] num,
                                                       input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] nm;
        logic [DATA_W-1:0] dm;
        logic [DATA_W-1:0] q;
        nm = num[DATA_W-1] ? -num : num;
        dm = den[DATA_W-1] ? -den : den;
        if (dm == '0)
        begin
            dz_seen = 1'b1;
            return '0;
        end
        q = nm / dm;
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
    endfunction

    function automatic void evaluate_symbol(input logic [7:0] sym, input logic fin);
        logic [DATA_W-1:0] newer;
        logic [DATA_W-1:0] older;
        eval_result_t      res;
        if (!skip_rest)
        begin
            if (sym == CH_NUL)
            begin
                skip_rest = 1'b1;
            end
            else if (sym >= CH_ZERO && sym <= CH_NINE)
            begin
                push_operand(DATA_W'(sym - CH_ZERO));
            end
            else
            begin
                newer = pop_operand();
                older = pop_operand();
                case (sym)
                    CH_PLUS:  last_value = older + newer;
                    CH_MINUS: last_value = older - newer;
                    CH_STAR:  last_value = older * newer;
                    CH_SLASH: last_value = divide_trunc(older, newer);
                    default:  ;
                endcase
                push_operand(last_value);
            end
        end
        if (fin)
        begin
            res.result          = pop_operand();
            res.divide_by_zero  = dz_seen;
            res.stack_overflow  = ovf_seen;
            res.stack_underflow = unf_seen;
            expected_results.push_back(res);
            clear_expression();
        end
    endfunction

    task automatic send_symbol(input logic [7:0] sym, input logic fin);
        while (gaps_on && $urandom_range(99) < GAP_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        evaluate_symbol(sym, fin);
        items_sent++;
    endtask

    task automatic send_expression(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_symbol(text[i], i == text.len() - 1);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] random_operator();
        logic [7:0] sym;
        int         r;
        r = $urandom_range(9);
        if (r < 2)
        begin
            return CH_PLUS;
        end
        if (r < 4)
        begin
            return CH_MINUS;
        end
        if (r < 6)
        begin
            return CH_STAR;
        end
        if (r < 9)
        begin
            return CH_SLASH;
        end
        do
            sym = 8'($urandom_range(1, 255));
        while (sym >= CH_ZERO && sym <= CH_NINE);
        return sym;
    endfunction

    // well-formed unless noisy; depth only tracks the clean shape
    task automatic send_random_expression(input int target_len, input int push_pct,
                                          input bit noisy);
        int         depth;
        int         count;
        int         r;
        logic [7:0] sym;
        logic       fin;
        depth = 0;
        count = 0;
        fin   = 1'b0;
        while (!fin)
        begin
            r = $urandom_range(99);
            if (noisy && r < 3)
                sym = CH_NUL;
            else if (noisy && r < 15)
                sym = 8'($urandom_range(255));
            else if (depth < 2 || (count < target_len && $urandom_range(99) < push_pct))
                sym = random_digit();
            else
                sym = random_operator();
            count++;
            if (sym >= CH_ZERO && sym <= CH_NINE)
                depth++;
            else if (depth > 1)
                depth--;
            else
                depth = 1;
            fin = (count >= target_len && depth == 1) || count >= 2 * target_len + 8
                  || (noisy && $urandom_range(99) < 5);
            send_symbol(sym, fin);
        end
    endtask

    task automatic test_arithmetic();
        send_expression("0");
        send_expression("34+");
        send_expression("52-");
        send_expression("67*");
        send_expression("83/");
        send_expression("703-/");
    endtask

    task automatic test_other_byte();
        send_expression("62-?");
    endtask

    task automatic test_zero_byte();
        send_symbol(CH_ZERO + 8'd7, 1'b0);
        send_symbol(CH_NUL, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(CH_PLUS, 1'b1);
    endtask

    task automatic test_divide_by_zero();
        send_expression("50/");
    endtask

    task automatic test_empty_stack();
        send_symbol(CH_NUL, 1'b1);
        send_symbol(CH_PLUS, 1'b1);
    endtask

    task automatic test_stack_overflow();
        repeat (STACK_DEPTH + 1) send_symbol(CH_NINE, 1'b0);
        send_symbol(CH_PLUS, 1'b1);
        send_expression("1");
    endtask

    task automatic test_extreme_values();
        send_expression("88*88**88*88***88**2*1-");
        send_expression("88*88**88*88***88**2*01-/");
    endtask

    task automatic test_random_expressions(input int item_goal, input bit noisy);
        while (items_sent < item_goal)
        begin
            if ($urandom_range(29) == 0)
                send_random_expression($urandom_range(34, 48), 95, noisy);
            else
                send_random_expression($urandom_range(1, 12), 50,
                                       noisy || $urandom_range(9) == 0);
        end
    endtask

    task automatic test_without_idling(input int item_goal);
        gaps_on <= 1'b0;
        test_random_expressions(item_goal, 1'b0);
        wait_for_results();
        gaps_on <= 1'b1;
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] expected,
                                 input logic [DATA_W-1:0] actual);
        if (actual !== expected)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
        end
    endtask

    task automatic check_result();
        eval_result_t exp_res;
        if (expected_results.size() == 0)
        begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $error("result 0x%0h with no expression pending", m_axis_tdata);
            return;
        end
        exp_res = expected_results.pop_front();
        compare_field("result", exp_res.result, m_axis_tdata);
        compare_field("divide_by_zero", exp_res.divide_by_zero, m_axis_tuser[0]);
        compare_field("stack_overflow", exp_res.stack_overflow, m_axis_tuser[1]);
        compare_field("stack_underflow", exp_res.stack_underflow, m_axis_tuser[2]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
        m_axis_tready <= gaps_on ? ($urandom_range(99) >= GAP_PCT) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        gaps_on       = 1'b1;
        err_count     = 0;
        items_sent    = 0;
        stall_cycles  = 0;
        clear_expression();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_arithmetic();
        test_other_byte();
        test_zero_byte();
        test_divide_by_zero();
        test_empty_stack();
        wait_for_results();
        test_stack_overflow();
        test_extreme_values();
        wait_for_results();
        test_random_expressions(950, 1'b0);
        wait_for_results();
        test_without_idling(1350);
        test_random_expressions(1600, 1'b1);
        wait_for_results();
        test_random_expressions(1750, 1'b0);
        wait_for_results();

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_alu.sv
rtl/core/postfix_stack_evaluator.sv
tb/tb_postfix_stack_evaluator.sv
